[rtl/sls_pkg.sv]
// Package for the sleep level selector: request/response types, level table,
// configuration register indexes and effective-vote helpers. No dependencies.
`default_nettype none

package sls_pkg;

    localparam int unsigned LEVELS    = 8;
    localparam int unsigned LANES     = 6;
    localparam int unsigned DIV_BITS  = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OSC_VOTE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OSC_LPEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_VOTE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_LPEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_VOTE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGIC_VOTE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGIC_MODE = 3'd7;

    localparam logic [1:0] KIND_WFI      = 2'd0;
    localparam logic [1:0] KIND_STANDALONE = 2'd1;
    localparam logic [1:0] KIND_COLLAPSE = 2'd2;

    localparam logic [1:0] RAIL_MODE_ACTIVE = 2'd0;
    localparam logic [1:0] RAIL_MODE_RET    = 2'd1;

    localparam logic [11:0] VDD_FLOOR_ACTIVE = 12'd1000;
    localparam logic [11:0] VDD_FLOOR_RET    = 12'd750;
    localparam logic [11:0] VDD_FLOOR_LOW    = 12'd500;

    localparam logic [11:0] RST_RAIL_VOTE = 12'd1000;

    localparam logic [1:0]  LVL_KIND      [LEVELS] = '{2'd0, 2'd1, 2'd2, 2'd2,
                                                       2'd2, 2'd2, 2'd2, 2'd2};
    localparam logic        LVL_OSC_LIMIT [LEVELS] = '{1'b1, 1'b1, 1'b1, 1'b0,
                                                       1'b1, 1'b0, 1'b0, 1'b0};
    localparam logic [1:0]  LVL_L2_LIMIT  [LEVELS] = '{2'd3, 2'd3, 2'd3, 2'd3,
                                                       2'd0, 2'd0, 2'd0, 2'd0};
    localparam logic [11:0] LVL_RAIL_UPPER[LEVELS] = '{12'd1250, 12'd1250, 12'd1250,
                                                       12'd1250, 12'd1250, 12'd1250,
                                                       12'd1000, 12'd750};
    localparam logic [12:0] LVL_LATENCY   [LEVELS] = '{13'd1, 13'd1500, 13'd1800,
                                                       13'd3800, 13'd2800, 13'd4800,
                                                       13'd6800, 13'd7800};
    localparam logic [14:0] LVL_STEADY    [LEVELS] = '{15'd20000, 15'd5000, 15'd5000,
                                                       15'd4500, 15'd2500, 15'd2000,
                                                       15'd500, 15'd0};
    localparam logic [31:0] LVL_ENERGY    [LEVELS] = '{32'd100000, 32'd60100000,
                                                       32'd60350000, 32'd65350000,
                                                       32'd66850000, 32'd71850000,
                                                       32'd75850000, 32'd76350000};
    localparam logic [13:0] LVL_TIME_OH   [LEVELS] = '{14'd1, 14'd3000, 14'd3500,
                                                       14'd5500, 14'd4800, 14'd6800,
                                                       14'd8800, 14'd9800};

    typedef struct packed {
        logic [1:0]  sleep_kind;
        logic [31:0] latency_budget;
        logic [31:0] sleep_time;
    } t_sls_req;

    typedef struct packed {
        logic        found;
        logic [2:0]  level_index;
        logic [31:0] est_power;
        logic [12:0] level_latency;
    } t_sls_rsp;

    typedef enum logic [1:0] {
        BR_ENERGY,
        BR_DIV,
        BR_STEADY,
        BR_MIX
    } t_branch;

    typedef struct packed {
        logic        elig;
        logic [2:0]  lvl;
        t_branch     br;
        logic [31:0] num_a;
        logic [32:0] rem_a;
        logic [31:0] num_b;
        logic [32:0] rem_b;
    } t_lane;

    typedef struct packed {
        logic        elig;
        logic [2:0]  lvl;
        logic [31:0] pow;
    } t_cand;

    function automatic logic [11:0] rail_effective(input logic [11:0] vote,
                                                   input logic [1:0] mode);
        logic [11:0] floor_mv;
        case (mode)
            RAIL_MODE_ACTIVE: floor_mv = VDD_FLOOR_ACTIVE;
            RAIL_MODE_RET:    floor_mv = VDD_FLOOR_RET;
            default:          floor_mv = VDD_FLOOR_LOW;
        endcase
        return (vote > floor_mv) ? vote : floor_mv;
    endfunction

    // right side wins ties so the later level is kept
    function automatic t_cand pick(input t_cand l, input t_cand r);
        if (r.elig && (!l.elig || r.pow <= l.pow)) begin
            return r;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

[rtl/sleep_level_selector.sv]
// Sleep level selector: front register, divider, power register, selection tree, result register.
// Throughput one request per cycle; a held result stalls the whole pipeline.
// The divider is a 32-stage restoring divider, one quotient bit per stage.
// Synchronous active-low reset clears valid bits and configuration to defaults.
// Configuration writes are always accepted (ready always high).
`default_nettype none

module sleep_level_selector (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  sls_pkg::t_sls_req                i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output sls_pkg::t_sls_rsp                o_out_data,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [sls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [sls_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    import sls_pkg::*;

    // configuration
    logic        r_osc_vote, r_osc_lpen, r_l2_lpen;
    logic [1:0]  r_l2_vote, r_mem_mode, r_logic_mode;
    logic [11:0] r_mem_vote, r_logic_vote;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc_vote   <= 1'b1;
            r_osc_lpen   <= 1'b0;
            r_l2_vote    <= 2'd0;
            r_l2_lpen    <= 1'b0;
            r_mem_vote   <= RST_RAIL_VOTE;
            r_mem_mode   <= RAIL_MODE_ACTIVE;
            r_logic_vote <= RST_RAIL_VOTE;
            r_logic_mode <= RAIL_MODE_ACTIVE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OSC_VOTE:   r_osc_vote   <= i_cfg_data[0];
                CFG_OSC_LPEN:   r_osc_lpen   <= i_cfg_data[0];
                CFG_L2_VOTE:    r_l2_vote    <= i_cfg_data[1:0];
                CFG_L2_LPEN:    r_l2_lpen    <= i_cfg_data[0];
                CFG_MEM_VOTE:   r_mem_vote   <= i_cfg_data;
                CFG_MEM_MODE:   r_mem_mode   <= i_cfg_data[1:0];
                CFG_LOGIC_VOTE: r_logic_vote <= i_cfg_data;
                CFG_LOGIC_MODE: r_logic_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic        osc_eff;
    logic [1:0]  l2_eff;
    logic [11:0] mem_eff, logic_eff;

    assign osc_eff   = r_osc_lpen ? r_osc_vote : 1'b1;
    assign l2_eff    = r_l2_lpen ? r_l2_vote : 2'd3;
    assign mem_eff   = rail_effective(r_mem_vote, r_mem_mode);
    assign logic_eff = rail_effective(r_logic_vote, r_logic_mode);

    // global advance: the pipeline moves unless a held result is stalled
    logic adv;
    assign adv        = !o_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    // front stage: lane setup, branch choice and wrapping product
    t_lane n_front [LANES];

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            logic [2:0]  lv;
            logic        avail;
            logic [31:0] t;
            logic [31:0] oh;
            logic [31:0] prod;
            t  = i_in_data.sleep_time;
            lv = (i_in_data.sleep_kind == KIND_COLLAPSE) ? 3'(j + 2)
                                                         : {1'b0, i_in_data.sleep_kind};
            oh = {18'd0, LVL_TIME_OH[lv]};
            avail = (LVL_KIND[lv] != KIND_COLLAPSE) ||
                    (osc_eff <= LVL_OSC_LIMIT[lv] && l2_eff <= LVL_L2_LIMIT[lv] &&
                     mem_eff < LVL_RAIL_UPPER[lv] && logic_eff < LVL_RAIL_UPPER[lv]);
            prod = 32'((t - oh) * {17'd0, LVL_STEADY[lv]});
            n_front[j].elig = avail && (LVL_KIND[lv] == i_in_data.sleep_kind) &&
                              (i_in_data.latency_budget >= {19'd0, LVL_LATENCY[lv]}) &&
                              (j == 0 || i_in_data.sleep_kind == KIND_COLLAPSE);
            n_front[j].lvl  = lv;
            if (t <= 32'd1) begin
                n_front[j].br = BR_ENERGY;
            end else if (t <= oh) begin
                n_front[j].br = BR_DIV;
            end else if ((t >> 10) > oh) begin
                n_front[j].br = BR_STEADY;
            end else begin
                n_front[j].br = BR_MIX;
            end
            n_front[j].num_a = prod;
            n_front[j].rem_a = 33'd0;
            n_front[j].num_b = LVL_ENERGY[lv];
            n_front[j].rem_b = 33'd0;
        end
    end

    // divider pipeline: index 0 is the front register, index k holds k quotient bits
    logic        r_dv_valid [DIV_BITS+1];
    logic [31:0] r_dv_t     [DIV_BITS+1];
    t_lane       r_dv_lane  [DIV_BITS+1][LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (adv) begin
            r_dv_valid[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_t[0]    <= i_in_data.sleep_time;
            r_dv_lane[0] <= n_front;
        end
    end

    function automatic logic [64:0] div_step(input logic [32:0] rem, input logic [31:0] num,
                                             input logic [31:0] den);
        logic [32:0] a_sh;
        logic        ge;
        a_sh = {rem[31:0], num[31]};
        ge   = a_sh >= {1'b0, den};
        return {ge ? (a_sh - {1'b0, den}) : a_sh, num[30:0], ge};
    endfunction

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        t_lane n_lane [LANES];

        always_comb begin
            for (int j = 0; j < LANES; j++) begin
                logic [64:0] sa;
                logic [64:0] sb;
                sa = div_step(r_dv_lane[k][j].rem_a, r_dv_lane[k][j].num_a, r_dv_t[k]);
                sb = div_step(r_dv_lane[k][j].rem_b, r_dv_lane[k][j].num_b, r_dv_t[k]);
                n_lane[j]       = r_dv_lane[k][j];
                n_lane[j].rem_a = sa[64:32];
                n_lane[j].num_a = sa[31:0];
                n_lane[j].rem_b = sb[64:32];
                n_lane[j].num_b = sb[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else if (adv) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_t[k+1]    <= r_dv_t[k];
                r_dv_lane[k+1] <= n_lane;
            end
        end
    end

    // power per lane
    t_cand n_pow [LANES];
    t_cand r_pow [LANES];
    logic  r_pow_valid;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            t_lane ln;
            ln = r_dv_lane[DIV_BITS][j];
            n_pow[j].elig = ln.elig;
            n_pow[j].lvl  = ln.lvl;
            case (ln.br)
                BR_ENERGY: n_pow[j].pow = LVL_ENERGY[ln.lvl];
                BR_DIV:    n_pow[j].pow = ln.num_b;
                BR_STEADY: n_pow[j].pow = {17'd0, LVL_STEADY[ln.lvl]};
                default:   n_pow[j].pow = ln.num_a + ln.num_b;
            endcase
        end
    end

    // selection tree, three pairs then two levels
    t_cand r_sa [3];
    t_cand r_sb [2];
    logic  r_sa_valid, r_sb_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pow_valid <= 1'b0;
            r_sa_valid  <= 1'b0;
            r_sb_valid  <= 1'b0;
        end else if (adv) begin
            r_pow_valid <= r_dv_valid[DIV_BITS];
            r_sa_valid  <= r_pow_valid;
            r_sb_valid  <= r_sa_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pow   <= n_pow;
            r_sa[0] <= pick(r_pow[0], r_pow[1]);
            r_sa[1] <= pick(r_pow[2], r_pow[3]);
            r_sa[2] <= pick(r_pow[4], r_pow[5]);
            r_sb[0] <= pick(r_sa[0], r_sa[1]);
            r_sb[1] <= r_sa[2];
        end
    end

    // result register
    t_cand    best;
    t_sls_rsp n_out;
    logic     r_out_valid;
    t_sls_rsp r_out;

    always_comb begin
        best = pick(r_sb[0], r_sb[1]);
        n_out.found         = best.elig;
        n_out.level_index   = best.elig ? best.lvl : 3'd0;
        n_out.est_power     = best.elig ? best.pow : 32'd0;
        n_out.level_latency = best.elig ? LVL_LATENCY[best.lvl] : 13'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_sb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
        (o_out_data.level_index == 3'd0 && o_out_data.est_power == 32'd0 &&
         o_out_data.level_latency == 13'd0))
        else $error("empty result carries nonzero fields");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result held");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_found_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |-> o_out_data.level_latency != 13'd0)
        else $error("chosen level has no latency");

endmodule

`default_nettype wire
